FILE: src/lfsb_pkg.sv
// package for the light-field sub-aperture binning core
// types, state enum, register indexes and helpers; no dependencies
package lfsb_pkg;
	localparam int MAX_TILES_PER_AXIS_D = 5;
	localparam int MAX_OUT_WIDTH_D = 64;
	localparam int MAX_OUT_HEIGHT_D = 64;

	localparam logic [2:0] REG_SENSOR_W = 3'd0;
	localparam logic [2:0] REG_SENSOR_H = 3'd1;
	localparam logic [2:0] REG_OUT_W = 3'd2;
	localparam logic [2:0] REG_OUT_H = 3'd3;
	localparam logic [2:0] REG_TILES = 3'd4;

	localparam logic KIND_ACC = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] SEL_RED = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE = 2'd2;
	localparam logic [1:0] SEL_ALL = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIVX,
		ST_DIVY,
		ST_ADDR,
		ST_RD,
		ST_WR,
		ST_DIVR,
		ST_DIVG,
		ST_DIVB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] quo;
	} div_rsp_t;
endpackage

FILE: src/lfsb_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on lfsb_pkg
module lfsb_div (
	input  logic clk,
	input  logic arst_n,
	input  lfsb_pkg::div_req_t req,
	output lfsb_pkg::div_rsp_t rsp
);
	import lfsb_pkg::*;
	logic [31:0] quo_q, den_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [32:0] trial;
	always_comb trial = {rem_q[31:0], quo_q[31]} - {1'b0, den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

FILE: src/lfsb_store.sv
// pixel store: three sum planes and packed counts, registered read
// depends on lfsb_pkg
module lfsb_store #(
	parameter int DEPTH = 102400,
	parameter int AW = 17
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [131:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [131:0] rdata
);
	import lfsb_pkg::*;
	logic [131:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: src/lightfield_subaperture_binning_core.sv
// light-field sub-aperture binning core top level
// depends on lfsb_pkg, lfsb_div, lfsb_store
//
// channel  dir  tdata/fields
// s_axis   in   kind in tuser, sample or read request in tdata
// m_axis   out  accepted and averages/counts
// cfg      in   register index and write data
//
// an accumulate runs two divider passes for the pixel position, x then y,
// plus address, read, update and output steps
// a read runs one divider pass per channel; a channel with a zero count skips its pass
// a dropped sample or an out-of-range read goes from the address step straight to output
// after reset a clearing pass over all DEPTH entries (102400 by default) runs before any request
// the result waits in an output register; the next request is taken once it drains
module lightfield_subaperture_binning_core #(
	parameter int MAX_TILES_PER_AXIS = lfsb_pkg::MAX_TILES_PER_AXIS_D,
	parameter int MAX_OUT_WIDTH = lfsb_pkg::MAX_OUT_WIDTH_D,
	parameter int MAX_OUT_HEIGHT = lfsb_pkg::MAX_OUT_HEIGHT_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// ang_u, ang_v, sensor_x, sensor_y, colour_sel, value_red, value_green,
	// value_blue, read_tile, read_px, read_py, zero pad to 120
	input  logic [119:0] s_axis_tdata,
	// kind
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// accepted, avg_red, avg_green, avg_blue, count_red, count_green,
	// count_blue, zero pad to 88
	output logic [87:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [12:0] cfg_data
);
	import lfsb_pkg::*;
	localparam int PIX = MAX_OUT_WIDTH * MAX_OUT_HEIGHT;
	localparam int DEPTH = MAX_TILES_PER_AXIS * MAX_TILES_PER_AXIS * PIX;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(MAX_OUT_WIDTH + 1);
	localparam int YW = $clog2(MAX_OUT_HEIGHT + 1);
	localparam int TW = $clog2(MAX_TILES_PER_AXIS + 1);

	logic [12:0] sw_q, sh_q;
	logic [6:0] ow_q, oh_q;
	logic [2:0] tp_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= 13'd4096;
			sh_q <= 13'd4096;
			ow_q <= 7'd64;
			oh_q <= 7'd64;
			tp_q <= 3'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SENSOR_W: sw_q <= cfg_data;
				REG_SENSOR_H: sh_q <= cfg_data;
				REG_OUT_W: ow_q <= cfg_data[6:0];
				REG_OUT_H: oh_q <= cfg_data[6:0];
				REG_TILES: tp_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic [10:0] ow_e, oh_e;
	logic [4:0] tp_e;
	logic [12:0] sw_e, sh_e;
	always_comb begin
		sw_e = (sw_q == 13'd0) ? 13'd1 : sw_q;
		sh_e = (sh_q == 13'd0) ? 13'd1 : sh_q;
		ow_e = (ow_q == 7'd0) ? 11'd1 :
			(32'(ow_q) > MAX_OUT_WIDTH) ? 11'(MAX_OUT_WIDTH) : 11'(ow_q);
		oh_e = (oh_q == 7'd0) ? 11'd1 :
			(32'(oh_q) > MAX_OUT_HEIGHT) ? 11'(MAX_OUT_HEIGHT) : 11'(oh_q);
		tp_e = (tp_q == 3'd0) ? 5'd1 :
			(32'(tp_q) > MAX_TILES_PER_AXIS) ? 5'(MAX_TILES_PER_AXIS) : 5'(tp_q);
	end

	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [118:0] in_q;
	logic kind_q;
	logic ok_q;
	logic [31:0] tx_q, ty_q;
	logic [AW-1:0] addr_q;
	logic [131:0] ent_q;
	logic [87:0] out_q;
	logic ovalid_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [AW-1:0] raddr;
	logic we;
	logic [AW-1:0] waddr;
	logic [131:0] wdata, rdata;

	lfsb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	lfsb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata));

	logic signed [15:0] au, av;
	logic [15:0] sx, sy;
	logic [1:0] sel;
	logic [11:0] vr, vg, vb;
	logic [4:0] rt;
	logic [5:0] rpx, rpy;
	always_comb begin
		au = in_q[15:0];
		av = in_q[31:16];
		sx = in_q[47:32];
		sy = in_q[63:48];
		sel = in_q[65:64];
		vr = in_q[77:66];
		vg = in_q[89:78];
		vb = in_q[101:90];
		rt = in_q[106:102];
		rpx = in_q[112:107];
		rpy = in_q[118:113];
	end

	logic [31:0] mag;
	logic [TW-1:0] iu, iv;
	logic [20:0] uo, vo;
	logic [4:0] tile_a;
	logic [XW-1:0] cx;
	logic [YW-1:0] cy;
	logic read_ok;
	always_comb begin
		mag = 32'($signed(au) * $signed(au)) + 32'($signed(av) * $signed(av));
		uo = 21'({1'b0, au ^ 16'h8000}) * 21'(tp_e);
		vo = 21'({1'b0, av ^ 16'h8000}) * 21'(tp_e);
		iu = TW'(uo[20:16]);
		iv = TW'(vo[20:16]);
		tile_a = 5'(iu) + 5'(tp_e * 5'(iv));
		cx = (tx_q > 32'(ow_e) - 32'd1) ? XW'(ow_e - 11'd1) : XW'(tx_q);
		cy = (ty_q > 32'(oh_e) - 32'd1) ? YW'(oh_e - 11'd1) : YW'(ty_q);
		read_ok = (10'(rt) < 10'(tp_e) * 10'(tp_e)) && (11'(rpx) < ow_e)
			&& (11'(rpy) < oh_e);
	end

	logic [15:0] cr, cg, cb;
	logic [27:0] sr, sg, sb;
	logic addr_ok;
	always_comb begin
		sr = ent_q[27:0];
		sg = ent_q[55:28];
		sb = ent_q[83:56];
		cr = ent_q[99:84];
		cg = ent_q[115:100];
		cb = ent_q[131:116];
	end

	logic [31:0] pre_addr;
	always_comb begin
		if (kind_q == KIND_READ)
			pre_addr = 32'(rt) * 32'(PIX) + 32'(rpy) * 32'(MAX_OUT_WIDTH) + 32'(rpx);
		else
			pre_addr = 32'(tile_a) * 32'(PIX) + 32'(cy) * 32'(MAX_OUT_WIDTH) + 32'(cx);
		addr_ok = pre_addr < 32'(DEPTH);
	end

	logic [131:0] upd;
	logic add_r, add_g, add_b;
	always_comb begin
		add_r = (sel == SEL_RED || sel == SEL_ALL) && rdata[99:84] != 16'hFFFF;
		add_g = (sel == SEL_GREEN || sel == SEL_ALL) && rdata[115:100] != 16'hFFFF;
		add_b = (sel == SEL_BLUE || sel == SEL_ALL) && rdata[131:116] != 16'hFFFF;
		upd = rdata;
		if (add_r) begin
			upd[27:0] = rdata[27:0] + 28'(vr);
			upd[99:84] = rdata[99:84] + 16'd1;
		end
		if (add_g) begin
			upd[55:28] = rdata[55:28] + 28'(vg);
			upd[115:100] = rdata[115:100] + 16'd1;
		end
		if (add_b) begin
			upd[83:56] = rdata[83:56] + 28'(vb);
			upd[131:116] = rdata[131:116] + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		dreq = '0;
		we = 1'b0;
		waddr = addr_q;
		wdata = '0;
		raddr = addr_q;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				if (32'(clr_q) == DEPTH - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_axis_tready = !ovalid_q;
				if (s_axis_tvalid && !ovalid_q) state_d = ST_ADDR;
			end
			ST_ADDR: begin
				if (kind_q == KIND_READ) begin
					state_d = (read_ok && addr_ok) ? ST_RD : ST_OUT;
				end else if (mag >= 32'h4000_0000) begin
					state_d = ST_OUT;
				end else begin
					dreq.start = 1'b1;
					dreq.num = 32'(sx) * 32'(ow_e);
					dreq.den = {15'd0, sw_e, 4'd0};
					state_d = ST_DIVX;
				end
			end
			ST_DIVX: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = 32'(sy) * 32'(oh_e);
				dreq.den = {15'd0, sh_e, 4'd0};
				state_d = ST_DIVY;
			end
			ST_DIVY: if (drsp.done) state_d = ST_RD;
			ST_RD: begin
				raddr = AW'(pre_addr);
				state_d = ST_WR;
			end
			ST_WR: begin
				if (kind_q == KIND_ACC) begin
					if (ok_q) begin
						we = 1'b1;
						wdata = upd;
					end
					state_d = ST_OUT;
				end else begin
					if (rdata[99:84] != 16'd0) begin
						dreq.start = 1'b1;
						dreq.num = 32'(rdata[27:0]);
						dreq.den = 32'(rdata[99:84]);
					end
					state_d = ST_DIVR;
				end
			end
			ST_DIVR: if (drsp.done || !drsp.busy) begin
				if (cg != 16'd0) begin
					dreq.start = 1'b1;
					dreq.num = 32'(sg);
					dreq.den = 32'(cg);
				end
				state_d = ST_DIVG;
			end
			ST_DIVG: if (drsp.done || !drsp.busy) begin
				if (cb != 16'd0) begin
					dreq.start = 1'b1;
					dreq.num = 32'(sb);
					dreq.den = 32'(cb);
				end
				state_d = ST_DIVB;
			end
			ST_DIVB: if (drsp.done || !drsp.busy) state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_OUT) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				in_q <= s_axis_tdata[118:0];
				kind_q <= s_axis_tuser;
				if (s_axis_tvalid && !ovalid_q) begin
					out_q <= '0;
					ok_q <= 1'b0;
				end
			end
			ST_ADDR: if (kind_q == KIND_READ) ok_q <= read_ok && addr_ok;
			ST_DIVY: if (drsp.done) ty_q <= drsp.quo;
			ST_DIVX: if (drsp.done) tx_q <= drsp.quo;
			ST_RD: begin
				addr_q <= AW'(pre_addr);
				if (kind_q == KIND_ACC) ok_q <= addr_ok;
			end
			ST_WR: begin
				ent_q <= (kind_q == KIND_ACC) ? upd : rdata;
				out_q[0] <= ok_q;
				if (kind_q == KIND_READ) begin
					out_q[37 +: 16] <= rdata[99:84];
					out_q[53 +: 16] <= rdata[115:100];
					out_q[69 +: 16] <= rdata[131:116];
				end
			end
			ST_DIVR: if (drsp.done) out_q[12:1] <= drsp.quo[11:0];
			ST_DIVG: if (drsp.done) out_q[24:13] <= drsp.quo[11:0];
			ST_DIVB: if (drsp.done) out_q[36:25] <= drsp.quo[11:0];
			default: ;
		endcase
	end

	always_comb begin
		m_axis_tvalid = ovalid_q;
		m_axis_tdata = out_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("request taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_CLEAR || state_q == ST_WR))
		else $error("store write outside clear or update");
	assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy)
		else $error("divider restarted while busy");
endmodule
